[hw/rtl/sspg_pkg.sv]
package sspg_pkg;

  // Field widths
  localparam int unsigned OP_W     = 2;
  localparam int unsigned STEP_W   = 16;
  localparam int unsigned DUR_W    = 16;
  localparam int unsigned MAG_W    = 17;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned DELAY_W  = 16;
  localparam int unsigned HALF_W   = 15;
  localparam int unsigned IDX_W    = 8;
  localparam int unsigned END_W    = 34;
  localparam int unsigned PULSE_W  = 17;
  localparam int unsigned DVD_W    = 26;

  // Opcodes
  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_START  = 2'd1;
  localparam logic [OP_W-1:0] OP_SYMBOL = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_BUSY    = 2'd2;
  localparam logic [1:0] ST_NOTHING = 2'd3;

  // Arithmetic constants
  localparam logic [DVD_W-1:0]    US_PER_MS    = 26'd1000;
  localparam logic [MAG_W-1:0]    MAG_NEG_BASE = 17'h10000;
  localparam logic [PERIOD_W-1:0] PERIOD_MAX   = 16'hFFFF;
  localparam logic [HALF_W-1:0]   DELAY_HALF   = 15'd500;

  // Stored segment
  typedef struct packed {
    logic [MAG_W-1:0]    mag;
    logic                neg;
    logic [PERIOD_W-1:0] period;
    logic [DELAY_W-1:0]  delay;
  } seg_t;

  // One result word
  typedef struct packed {
    logic [1:0]        status;
    logic              symbol_valid;
    logic              pulse_level;
    logic [HALF_W-1:0] first_half_us;
    logic [HALF_W-1:0] second_half_us;
    logic              direction;
    logic [IDX_W-1:0]  segment_index;
    logic [END_W-1:0]  segment_end_us;
    logic              done_res;
  } res_t;

  // Run modes
  typedef enum logic [3:0] {
    MODE_IDLE      = 4'b0001,
    MODE_LOADING   = 4'b0010,
    MODE_EXECUTING = 4'b0100,
    MODE_COMPLETE  = 4'b1000
  } mode_t;

  // Sequencer states
  typedef enum logic [6:0] {
    S_IDLE       = 7'b0000001,
    S_DIV        = 7'b0000010,
    S_STORE      = 7'b0000100,
    S_START_WAIT = 7'b0001000,
    S_SCAN       = 7'b0010000,
    S_SCAN_WAIT  = 7'b0100000,
    S_EMIT       = 7'b1000000
  } state_t;

endpackage

[hw/rtl/sspg_div.sv]
module sspg_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [sspg_pkg::DVD_W-1:0]     dividend,
  input  logic [sspg_pkg::MAG_W-1:0]     divisor,
  output logic                           done,
  output logic [sspg_pkg::DVD_W-1:0]     quotient
);

  localparam int unsigned DW  = sspg_pkg::DVD_W;
  localparam int unsigned MW  = sspg_pkg::MAG_W;
  localparam int unsigned CNT_W = $clog2(DW);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [MW-1:0]    rem_r, rem_nxt;
  logic [DW-1:0]    quo_r, quo_nxt;
  logic [MW-1:0]    dsr_r, dsr_nxt;
  logic [MW:0]      shifted;
  logic [MW+1:0]    diff;
  logic             ge;

  // One restoring step: shift in a dividend bit, try the subtract
  always_comb begin
    shifted = {rem_r, quo_r[DW-1]};
    diff    = {1'b0, shifted} - {2'b00, dsr_r};
    ge      = ~diff[MW+1];
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DW - 1);
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[MW-1:0] : shifted[MW-1:0];
      quo_nxt = {quo_r[DW-2:0], ge};
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

[hw/rtl/sspg_seg_mem.sv]
module sspg_seg_mem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  sspg_pkg::seg_t       wr_data,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  output sspg_pkg::seg_t       rd_data
);

  sspg_pkg::seg_t mem [DEPTH];
  sspg_pkg::seg_t rd_data_r;

  // Write one segment
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[hw/rtl/stepper_segment_pulse_generator_top.sv]
// Step pulse generator for one stepper axis. A load word stores a segment (signed step
// count, duration in ms) and returns the running end time of the list in us; a start word
// rewinds the list; each symbol word returns the next step pulse (half period high, half
// low) or a 1 ms delay symbol, or a done result at the end of the list. Every word is
// handled on its own: a load is accepted, then the restoring divider works out
// 1000*duration/|steps| one quotient bit per cycle, the done check clamps the period, the
// segment is stored and the result is emitted; a load of an all-delay segment skips the
// divider, and one refused as busy or full goes straight to the result. A start makes one
// registered read of segment 0, or none with nothing loaded. A symbol looks at each segment
// through the one read port of the segment memory, one read for every exhausted segment
// passed over. A finished result waits in the output register while the next word is
// taken, and a stall on the result channel holds a word back from the output register.
// The segment memory has no clearing pass and is usable straight after reset.
module stepper_segment_pulse_generator_top #(
  parameter int unsigned SEGMENT_DEPTH = 256
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [sspg_pkg::OP_W-1:0]           in_opcode,
  input  logic signed [sspg_pkg::STEP_W-1:0]  in_step_count_in,
  input  logic [sspg_pkg::DUR_W-1:0]          in_duration_ms,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          out_status,
  output logic                                out_symbol_valid,
  output logic                                out_pulse_level,
  output logic [sspg_pkg::HALF_W-1:0]         out_first_half_us,
  output logic [sspg_pkg::HALF_W-1:0]         out_second_half_us,
  output logic                                out_direction,
  output logic [sspg_pkg::IDX_W-1:0]          out_segment_index,
  output logic [sspg_pkg::END_W-1:0]          out_segment_end_us,
  output logic                                out_done_res
);

  localparam int unsigned AW = (SEGMENT_DEPTH > 1) ? $clog2(SEGMENT_DEPTH) : 1;
  localparam int unsigned CW = $clog2(SEGMENT_DEPTH + 1);

  localparam int unsigned MAG_W    = sspg_pkg::MAG_W;
  localparam int unsigned DUR_W    = sspg_pkg::DUR_W;
  localparam int unsigned DVD_W    = sspg_pkg::DVD_W;
  localparam int unsigned END_W    = sspg_pkg::END_W;
  localparam int unsigned PERIOD_W = sspg_pkg::PERIOD_W;
  localparam int unsigned DELAY_W  = sspg_pkg::DELAY_W;
  localparam int unsigned PULSE_W  = sspg_pkg::PULSE_W;
  localparam int unsigned IDX_W    = sspg_pkg::IDX_W;

  // Control state
  sspg_pkg::state_t       state_r, state_nxt;
  sspg_pkg::mode_t        mode_r, mode_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic [END_W-1:0]       end_r, end_nxt;
  logic [CW-1:0]          pos_r, pos_nxt;
  logic [PULSE_W-1:0]     pulses_r, pulses_nxt;
  logic [DELAY_W-1:0]     delays_r, delays_nxt;
  logic                   out_valid_r, out_valid_nxt;

  // Working payload
  logic [DUR_W-1:0]       dur_r, dur_nxt;
  logic [MAG_W-1:0]       mag_r, mag_nxt;
  logic                   neg_r, neg_nxt;
  logic [DVD_W-1:0]       dvd_r, dvd_nxt;
  logic [PERIOD_W-1:0]    period_r, period_nxt;
  logic [DELAY_W-1:0]     delay_r, delay_nxt;
  sspg_pkg::res_t         res_r, res_nxt;
  sspg_pkg::res_t         out_r, out_nxt;

  // Divider and shared segment memory
  logic                   div_start;
  logic                   div_done;
  logic [DVD_W-1:0]       div_quo;
  logic                   wr_en;
  sspg_pkg::seg_t         wr_data;
  logic                   rd_en;
  logic [AW-1:0]          rd_addr;
  sspg_pkg::seg_t         rd_data;

  logic                   in_accept;
  logic                   slot_free;
  logic                   in_neg;
  logic [MAG_W-1:0]       in_mag;
  logic                   list_full;
  logic [MAG_W+6:0]       mag_x65;

  sspg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dvd_nxt),
    .divisor  (mag_nxt),
    .done     (div_done),
    .quotient (div_quo)
  );

  sspg_seg_mem #(
    .DEPTH (SEGMENT_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_stall  = (state_r != sspg_pkg::S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;

  // Magnitude and direction of the incoming step count
  assign in_neg  = in_step_count_in[sspg_pkg::STEP_W-1];
  assign in_mag  = in_neg ? (sspg_pkg::MAG_NEG_BASE - MAG_W'(unsigned'(in_step_count_in)))
                          : MAG_W'(unsigned'(in_step_count_in));
  assign mag_x65 = {mag_r, 6'b000000} + (MAG_W + 7)'(mag_r);
  assign list_full = (mode_r == sspg_pkg::MODE_LOADING) && (count_r >= CW'(SEGMENT_DEPTH));

  assign wr_data = '{mag: mag_r, neg: neg_r, period: period_r, delay: delay_r};

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    count_nxt     = count_r;
    end_nxt       = end_r;
    pos_nxt       = pos_r;
    pulses_nxt    = pulses_r;
    delays_nxt    = delays_r;
    dur_nxt       = dur_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    dvd_nxt       = dvd_r;
    period_nxt    = period_r;
    delay_nxt     = delay_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    div_start     = 1'b0;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = pos_r[AW-1:0];

    unique case (state_r)
      sspg_pkg::S_IDLE: begin
        if (in_accept) begin
          res_nxt   = '0;
          dur_nxt   = in_duration_ms;
          mag_nxt   = in_mag;
          neg_nxt   = in_neg;
          dvd_nxt   = DVD_W'(in_duration_ms) * sspg_pkg::US_PER_MS;
          state_nxt = sspg_pkg::S_EMIT;
          unique case (in_opcode)
            sspg_pkg::OP_LOAD: begin
              if (mode_r == sspg_pkg::MODE_EXECUTING) begin
                res_nxt.status = sspg_pkg::ST_BUSY;
              end else if (list_full) begin
                res_nxt.status = sspg_pkg::ST_FULL;
              end else begin
                // Empty the list when starting a fresh load
                if (mode_r != sspg_pkg::MODE_LOADING) begin
                  count_nxt = '0;
                  end_nxt   = '0;
                  mode_nxt  = sspg_pkg::MODE_LOADING;
                end
                if (in_mag == '0) begin
                  period_nxt = '0;
                  delay_nxt  = in_duration_ms;
                  state_nxt  = sspg_pkg::S_STORE;
                end else begin
                  // Hand the divider its operands as they are registered
                  div_start = 1'b1;
                  state_nxt = sspg_pkg::S_DIV;
                end
              end
            end
            sspg_pkg::OP_START: begin
              if (count_r == '0) begin
                res_nxt.status = sspg_pkg::ST_NOTHING;
              end else begin
                mode_nxt   = sspg_pkg::MODE_EXECUTING;
                pos_nxt    = '0;
                pulses_nxt = '0;
                delays_nxt = '0;
                rd_en      = 1'b1;
                rd_addr    = '0;
                state_nxt  = sspg_pkg::S_START_WAIT;
              end
            end
            sspg_pkg::OP_SYMBOL: begin
              if (mode_r == sspg_pkg::MODE_COMPLETE) begin
                res_nxt.done_res = 1'b1;
              end else if (mode_r != sspg_pkg::MODE_EXECUTING) begin
                res_nxt.status = sspg_pkg::ST_NOTHING;
              end else begin
                state_nxt = sspg_pkg::S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // Wait for the divider, then clamp the period and set the delay
      sspg_pkg::S_DIV: begin
        if (div_done) begin
          if (div_quo[DVD_W-1:PERIOD_W] != '0) begin
            period_nxt = sspg_pkg::PERIOD_MAX;
            delay_nxt  = dur_r - mag_x65[DELAY_W-1:0];
          end else begin
            period_nxt = div_quo[PERIOD_W-1:0];
            delay_nxt  = '0;
          end
          state_nxt = sspg_pkg::S_STORE;
        end
      end

      sspg_pkg::S_STORE: begin
        wr_en                  = 1'b1;
        end_nxt                = end_r + END_W'(dvd_r);
        count_nxt              = count_r + 1'b1;
        res_nxt.direction      = neg_r;
        res_nxt.segment_index  = IDX_W'(count_r[AW-1:0]);
        res_nxt.segment_end_us = end_r + END_W'(dvd_r);
        state_nxt              = sspg_pkg::S_EMIT;
      end

      sspg_pkg::S_START_WAIT: begin
        res_nxt.direction = rd_data.neg;
        state_nxt         = sspg_pkg::S_EMIT;
      end

      // Fetch the segment at the read position, or finish the list
      sspg_pkg::S_SCAN: begin
        if (pos_r < count_r) begin
          rd_en     = 1'b1;
          state_nxt = sspg_pkg::S_SCAN_WAIT;
        end else begin
          mode_nxt         = sspg_pkg::MODE_COMPLETE;
          res_nxt.done_res = 1'b1;
          state_nxt        = sspg_pkg::S_EMIT;
        end
      end

      sspg_pkg::S_SCAN_WAIT: begin
        res_nxt.direction     = rd_data.neg;
        res_nxt.segment_index = IDX_W'(pos_r[AW-1:0]);
        if (pulses_r < rd_data.mag) begin
          pulses_nxt             = pulses_r + 1'b1;
          res_nxt.symbol_valid   = 1'b1;
          res_nxt.pulse_level    = 1'b1;
          res_nxt.first_half_us  = rd_data.period[PERIOD_W-1:1];
          res_nxt.second_half_us = rd_data.period[PERIOD_W-1:1];
          state_nxt              = sspg_pkg::S_EMIT;
        end else if (delays_r < rd_data.delay) begin
          delays_nxt             = delays_r + 1'b1;
          res_nxt.symbol_valid   = 1'b1;
          res_nxt.pulse_level    = 1'b0;
          res_nxt.first_half_us  = sspg_pkg::DELAY_HALF;
          res_nxt.second_half_us = sspg_pkg::DELAY_HALF;
          state_nxt              = sspg_pkg::S_EMIT;
        end else begin
          // Segment exhausted: advance to the next one
          res_nxt.direction     = 1'b0;
          res_nxt.segment_index = '0;
          pulses_nxt            = '0;
          delays_nxt            = '0;
          pos_nxt               = pos_r + 1'b1;
          state_nxt             = sspg_pkg::S_SCAN;
        end
      end

      // Hand the word to the output register once it is free
      sspg_pkg::S_EMIT: begin
        if (slot_free) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = sspg_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = sspg_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sspg_pkg::S_IDLE;
      mode_r      <= sspg_pkg::MODE_IDLE;
      count_r     <= '0;
      end_r       <= '0;
      pos_r       <= '0;
      pulses_r    <= '0;
      delays_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      count_r     <= count_nxt;
      end_r       <= end_nxt;
      pos_r       <= pos_nxt;
      pulses_r    <= pulses_nxt;
      delays_r    <= delays_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dur_r    <= dur_nxt;
    mag_r    <= mag_nxt;
    neg_r    <= neg_nxt;
    dvd_r    <= dvd_nxt;
    period_r <= period_nxt;
    delay_r  <= delay_nxt;
    res_r    <= res_nxt;
    out_r    <= out_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_r.status;
  assign out_symbol_valid   = out_r.symbol_valid;
  assign out_pulse_level    = out_r.pulse_level;
  assign out_first_half_us  = out_r.first_half_us;
  assign out_second_half_us = out_r.second_half_us;
  assign out_direction      = out_r.direction;
  assign out_segment_index  = out_r.segment_index;
  assign out_segment_end_us = out_r.segment_end_us;
  assign out_done_res       = out_r.done_res;

endmodule
